>>> rtl/core/kble_pkg.sv
// Shared types, constants and codes of the keyboard line edit buffer.
`default_nettype none
package kble_pkg;

  // Characters the edit line can hold; one cell of the chain per character.
  localparam int unsigned LineCap = 63;
  localparam int unsigned PosW    = $clog2(LineCap + 1);
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [ByteW-1:0] ChNewline   = 8'h0A;
  localparam logic [ByteW-1:0] ChBackspace = 8'h08;
  localparam logic [ByteW-1:0] ChSpace     = 8'h20;
  localparam logic [ByteW-1:0] ChTilde     = 8'h7E;

  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_SUBMIT = 2'd1,
    OP_TAKE   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_MOVED  = 2'd1,
    ACT_EDITED = 2'd2,
    ACT_SUBMIT = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_TOOSMALL = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEFT      = 3'd0,
    CFG_RIGHT     = 3'd1,
    CFG_RIGHT_EXT = 3'd2,
    CFG_HOME      = 3'd3,
    CFG_SHIFT     = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_STREAM = 1'b1
  } state_e;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_ERASE  = 3'd2,
    CMD_SUBMIT = 3'd3,
    CMD_TAKE   = 3'd4
  } cell_cmd_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_cmd_e            cmd;
    logic [PosW-1:0]      pos;
    logic [ByteW-1:0]     ch;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/core/kble_cell.sv
// One character cell: an edit byte and a held byte, shifted with the neighbors.
`default_nettype none
module kble_cell (
  input  wire                        clk_i,
  input  kble_pkg::cell_ctrl_t       ctrl_i,
  input  wire [kble_pkg::PosW-1:0]   idx_i,
  input  wire [kble_pkg::ByteW-1:0]  left_edit_i,
  input  wire [kble_pkg::ByteW-1:0]  right_edit_i,
  input  wire [kble_pkg::ByteW-1:0]  right_held_i,
  output logic [kble_pkg::ByteW-1:0] edit_o,
  output logic [kble_pkg::ByteW-1:0] held_o
);
  import kble_pkg::*;

  logic [ByteW-1:0] edit_q, edit_d, held_q, held_d;

  always_comb begin
    edit_d = edit_q;
    held_d = held_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        // Cells right of the cursor take the left neighbor; the cursor cell loads.
        if (idx_i > ctrl_i.pos) begin
          edit_d = left_edit_i;
        end else if (idx_i == ctrl_i.pos) begin
          edit_d = ctrl_i.ch;
        end
      end
      CMD_ERASE: begin
        if (idx_i >= ctrl_i.pos) begin
          edit_d = right_edit_i;
        end
      end
      CMD_SUBMIT: held_d = edit_q;
      CMD_TAKE:   held_d = right_held_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    edit_q <= edit_d;
    held_q <= held_d;
  end

  assign edit_o = edit_q;
  assign held_o = held_q;

endmodule
`default_nettype wire

>>> rtl/core/kble_chain.sv
// Row of character cells holding the edit line and the submitted line.
`default_nettype none
module kble_chain (
  input  wire                        clk_i,
  input  kble_pkg::cell_ctrl_t       ctrl_i,
  output logic [kble_pkg::ByteW-1:0] head_held_o
);
  import kble_pkg::*;

  logic [ByteW-1:0] edit_w [LineCap];
  logic [ByteW-1:0] held_w [LineCap];

  for (genvar g = 0; g < LineCap; g++) begin : g_cell
    logic [ByteW-1:0] left_edit, right_edit, right_held;

    if (g == 0) begin : g_first
      assign left_edit = '0;
    end else begin : g_mid_l
      assign left_edit = edit_w[g-1];
    end

    if (g == LineCap - 1) begin : g_last
      assign right_edit = '0;
      assign right_held = '0;
    end else begin : g_mid_r
      assign right_edit = edit_w[g+1];
      assign right_held = held_w[g+1];
    end

    kble_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl_i),
      .idx_i        (PosW'(g)),
      .left_edit_i  (left_edit),
      .right_edit_i (right_edit),
      .right_held_i (right_held),
      .edit_o       (edit_w[g]),
      .held_o       (held_w[g])
    );
  end

  assign head_held_o = held_w[0];

endmodule
`default_nettype wire

>>> rtl/core/keyboard_line_edit_buffer.sv
// Top level of the keyboard line edit buffer: key decode, control and result register.
// Usage:
//   The slave stream carries one request per transaction. s_axis_tuser holds the
//   operation (key, submit, take, clear); s_axis_tdata holds the key event and the
//   reader's capacity. The master stream returns result transactions whose
//   tdata packs the outcome and the state after the step; tlast marks the final
//   result of a request.
//   Key, submit and clear requests produce one result, registered in the output
//   register. A take that succeeds produces held length plus one results, one per
//   cycle while the receiver accepts them, as the held line is shifted out of cell
//   0 of the character chain; the first byte is loaded into the output register
//   from the streaming state and the final one carries a zero byte. A failed take
//   gives one result. Every edit (insert or erase) updates all cells from the
//   cursor onward together; during a good take no new request is taken until
//   the final result has been loaded.
//   A new request is accepted while the previous single result still sits in
//   the output register, provided that register is being drained or is empty.
//   When the receiver stalls, the output register holds its transaction and no
//   new request or streamed byte is taken until it drains.
//   Reset clears the lengths, cursor, held flag and configuration registers to
//   their defaults; the cell contents are not cleared and are never read before
//   being written. Configuration writes are always accepted.
`default_nettype none
module keyboard_line_edit_buffer (
  input  wire        clk_i,
  input  wire        rst_ni,
  // Configuration write channel.
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire [kble_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire [7:0]  cfg_data_i,
  // Request stream.
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  // tdata: key_scan[7:0], character[15:8], modifiers[23:16], dest_capacity[31:24]
  input  wire [31:0] s_axis_tdata,
  // tuser: op[1:0]
  input  wire [1:0]  s_axis_tuser,
  // Result stream.
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  // tdata: action[1:0], overwritten[2], status[4:3], text_byte[12:5],
  //        line_len[18:13], cursor_position[24:19], line_ready[25],
  //        saved_length[31:26]
  output logic [31:0] m_axis_tdata,
  output logic       m_axis_tlast
);
  import kble_pkg::*;

  // Configuration registers.
  logic [7:0] left_scan_q, right_scan_q, right_ext_scan_q, home_scan_q, shift_mask_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_scan_q      <= 8'd75;
      right_scan_q     <= 8'd77;
      right_ext_scan_q <= 8'd205;
      home_scan_q      <= 8'd71;
      shift_mask_q     <= 8'd1;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LEFT:      left_scan_q      <= cfg_data_i;
        CFG_RIGHT:     right_scan_q     <= cfg_data_i;
        CFG_RIGHT_EXT: right_ext_scan_q <= cfg_data_i;
        CFG_HOME:      home_scan_q      <= cfg_data_i;
        CFG_SHIFT:     shift_mask_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state.
  state_e          state_q, state_d;
  logic [PosW-1:0] len_q, len_d, cur_q, cur_d, hlen_q, hlen_d, rem_q, rem_d;
  logic            hvalid_q, hvalid_d;

  // Output register.
  logic        m_valid_q, m_valid_d, m_last_q, m_last_d;
  logic [31:0] m_data_q, m_data_d;

  cell_ctrl_t       ctrl;
  logic [ByteW-1:0] head_held;

  kble_chain u_chain (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .head_held_o (head_held)
  );

  // Request fields.
  op_e              op;
  logic [ByteW-1:0] scan, chr, mods, cap;
  assign op   = op_e'(s_axis_tuser);
  assign scan = s_axis_tdata[7:0];
  assign chr  = s_axis_tdata[15:8];
  assign mods = s_axis_tdata[23:16];
  assign cap  = s_axis_tdata[31:24];

  logic out_free, accept, shift_held;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  action_e          res_act;
  status_e          res_stat;
  logic             res_ovw, res_last, res_load;
  logic [ByteW-1:0] res_byte;

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    cur_d      = cur_q;
    hlen_d     = hlen_q;
    hvalid_d   = hvalid_q;
    rem_d      = rem_q;
    ctrl.cmd   = CMD_NONE;
    ctrl.pos   = cur_q;
    ctrl.ch    = chr;
    res_act    = ACT_NONE;
    res_stat   = STAT_OK;
    res_ovw    = 1'b0;
    res_byte   = '0;
    res_last   = 1'b1;
    res_load   = 1'b0;
    shift_held = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          case (op)
            OP_KEY: begin
              if (chr == ChNewline) begin
                res_act = ACT_SUBMIT;
              end else if (chr == ChBackspace) begin
                if (cur_q != '0 && len_q != '0) begin
                  // Cells from the new cursor onward take their right neighbor.
                  cur_d    = cur_q - 1'b1;
                  len_d    = len_q - 1'b1;
                  ctrl.cmd = CMD_ERASE;
                  ctrl.pos = cur_q - 1'b1;
                  res_act  = ACT_EDITED;
                end
              end else if (scan == left_scan_q ||
                           (scan == right_scan_q && (mods & shift_mask_q) != '0)) begin
                if (cur_q != '0) begin
                  cur_d   = cur_q - 1'b1;
                  res_act = ACT_MOVED;
                end
              end else if (scan == right_ext_scan_q ||
                           (scan == right_scan_q && (mods & shift_mask_q) == '0)) begin
                if (cur_q < len_q) begin
                  cur_d   = cur_q + 1'b1;
                  res_act = ACT_MOVED;
                end
              end else if (scan == home_scan_q) begin
                if (cur_q != '0) begin
                  cur_d   = '0;
                  res_act = ACT_MOVED;
                end
              end else if (chr >= ChSpace && chr <= ChTilde) begin
                if (len_q < PosW'(LineCap)) begin
                  cur_d    = cur_q + 1'b1;
                  len_d    = len_q + 1'b1;
                  ctrl.cmd = CMD_INSERT;
                  res_act  = ACT_EDITED;
                end
              end
            end
            OP_SUBMIT: begin
              res_ovw  = hvalid_q;
              ctrl.cmd = CMD_SUBMIT;
              hlen_d   = len_q;
              hvalid_d = 1'b1;
              len_d    = '0;
              cur_d    = '0;
            end
            OP_CLEAR: begin
              len_d = '0;
              cur_d = '0;
            end
            OP_TAKE: begin
              if (!hvalid_q) begin
                res_stat = STAT_EMPTY;
              end else if (cap <= {{(ByteW-PosW){1'b0}}, hlen_q}) begin
                res_stat = STAT_TOOSMALL;
              end else begin
                // Successful take: results come from the streaming state.
                res_load = 1'b0;
                hvalid_d = 1'b0;
                rem_d    = hlen_q;
                state_d  = ST_STREAM;
              end
            end
            default: ;
          endcase
        end
      end
      ST_STREAM: begin
        if (out_free) begin
          res_load = 1'b1;
          if (rem_q == '0) begin
            res_last = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            res_byte   = head_held;
            res_last   = 1'b0;
            shift_held = 1'b1;
            rem_d      = rem_q - 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (shift_held) begin
      ctrl.cmd = CMD_TAKE;
    end

    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    if (res_load) begin
      m_valid_d = 1'b1;
      m_last_d  = res_last;
      m_data_d  = {hlen_d, hvalid_d, cur_d, len_d, res_byte, res_stat, res_ovw, res_act};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_q     <= '0;
      cur_q     <= '0;
      hlen_q    <= '0;
      hvalid_q  <= 1'b0;
      rem_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      cur_q     <= cur_d;
      hlen_q    <= hlen_d;
      hvalid_q  <= hvalid_d;
      rem_q     <= rem_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule
`default_nettype wire
